/* rtl/assert_macros.svh */
// Concurrent assertion helpers. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/mcps_pkg.sv */
package mcps_pkg;

    localparam int MAX_PATHS  = 4;
    localparam int PATH_W     = 2;
    localparam int WIN_W      = 40;
    localparam int UNACK_W    = 32;
    localparam int SIZE_W     = 16;
    localparam int MINW_W     = 16;
    localparam int FRAC_W     = 8;
    localparam int SQ_W       = 2 * SIZE_W;
    localparam int DIVIDEND_W = SQ_W + 16;
    localparam int PROD_W     = UNACK_W + WIN_W;

    localparam logic [WIN_W-1:0]  WIN_RESET  = 40'd128000;
    localparam logic [WIN_W-1:0]  WIN_MAX    = 40'hFF_FFFF_FFFF;
    localparam logic [MINW_W-1:0] MINW_RESET = 16'd500;

    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_ACK    = 1'b1;

    typedef logic [MAX_PATHS-1:0][UNACK_W-1:0] unacked_vec_t;

    // controller -> datapath
    typedef struct packed {
        logic load;          // capture an accepted input item
        logic idx_inc;       // advance scan index
        logic take;          // current path becomes best candidate
        logic mul_en;        // register partial products
        logic sum_en;        // register full cross products
        logic div_start;     // launch growth division
        logic win_wr_quick;  // write halved / zero-window value
        logic win_wr_grow;   // write grown window
        logic out_load;      // move result into output register
    } mcps_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_ack;        // op of the item at the input port
        logic elig;          // current path is eligible
        logic found;         // a candidate already exists
        logic last;          // scan index at last path
        logic ratio_less;    // current ratio below best ratio
        logic path_ok;       // ack path inside configured range
        logic loss;          // ack carries loss
        logic win_zero;      // acked path window is zero
        logic div_done;      // quotient ready
    } mcps_sts_t;

endpackage

/* rtl/mcps_div.sv */
module mcps_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [mcps_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [mcps_pkg::WIN_W-1:0]         divisor,
    output logic                               done,
    output logic [mcps_pkg::DIVIDEND_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(mcps_pkg::DIVIDEND_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mcps_pkg::DIVIDEND_W - 1);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [mcps_pkg::WIN_W-1:0]        rem_reg, rem_next;
    logic [mcps_pkg::DIVIDEND_W-1:0]   quo_reg, quo_next;
    logic [mcps_pkg::WIN_W-1:0]        dvs_reg, dvs_next;

    logic [mcps_pkg::WIN_W:0] shifted;
    logic [mcps_pkg::WIN_W:0] trial;
    logic                     borrow;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[mcps_pkg::DIVIDEND_W-1]};
        {borrow, trial} = {1'b0, shifted} - {2'b00, dvs_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = borrow ? shifted[mcps_pkg::WIN_W-1:0] : trial[mcps_pkg::WIN_W-1:0];
            quo_next = {quo_reg[mcps_pkg::DIVIDEND_W-2:0], ~borrow};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/mcps_dp.sv */
module mcps_dp #(
    parameter int NUM_PATHS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mcps_pkg::mcps_cmd_t               cmd,
    output mcps_pkg::mcps_sts_t               sts,
    input  logic                              cfg_wr_en,
    input  logic [mcps_pkg::MINW_W-1:0]       cfg_wr_data,
    input  logic                              op,
    input  logic [mcps_pkg::PATH_W-1:0]       ack_path,
    input  logic [mcps_pkg::SIZE_W-1:0]       ack_size,
    input  logic                              loss,
    input  mcps_pkg::unacked_vec_t            unacked,
    output logic                              path_found,
    output logic [mcps_pkg::PATH_W-1:0]       chosen_path,
    output logic [mcps_pkg::WIN_W-1:0]        new_window
);

    localparam int PIDX_W = (NUM_PATHS > 1) ? $clog2(NUM_PATHS) : 1;
    localparam logic [PIDX_W-1:0] IDX_LAST = PIDX_W'(NUM_PATHS - 1);
    localparam logic [mcps_pkg::PATH_W:0] NP = (mcps_pkg::PATH_W + 1)'(NUM_PATHS);

    localparam int WIN_W  = mcps_pkg::WIN_W;
    localparam int U_W    = mcps_pkg::UNACK_W;
    localparam int PROD_W = mcps_pkg::PROD_W;

    logic [WIN_W-1:0]           win_reg [NUM_PATHS];
    logic [mcps_pkg::MINW_W-1:0] minw_reg;
    logic [U_W-1:0]             u_reg [NUM_PATHS];
    logic                       op_reg;
    logic [mcps_pkg::PATH_W-1:0] path_reg;
    logic                       loss_reg;
    logic [mcps_pkg::SQ_W-1:0]  sq_reg;
    logic [PIDX_W-1:0]          idx_reg;
    logic [PIDX_W-1:0]          best_reg;
    logic                       found_reg;
    logic [U_W-1:0]             u_best_reg;
    logic [WIN_W-1:0]           w_best_reg;
    logic [2*U_W-1:0]           pl_lo_reg, pr_lo_reg;
    logic [WIN_W-1:0]           pl_hi_reg, pr_hi_reg;
    logic [PROD_W-1:0]          lhs_reg, rhs_reg;
    logic [WIN_W-1:0]           nw_reg;
    logic                       out_found_reg;
    logic [mcps_pkg::PATH_W-1:0] out_path_reg;
    logic [WIN_W-1:0]           out_win_reg;

    logic [PIDX_W-1:0]          rd_idx;
    logic [U_W-1:0]             u_cur;
    logic [WIN_W-1:0]           w_cur;
    logic [WIN_W-1:0]           half_w;
    logic [WIN_W-1:0]           floor_w;
    logic [WIN_W-1:0]           quick_val;
    logic [WIN_W:0]             grow_sum;
    logic [WIN_W-1:0]           grow_val;
    logic [WIN_W-1:0]           wr_val;
    logic                       win_wr;
    logic                       div_done;
    logic [mcps_pkg::DIVIDEND_W-1:0] quo;

    assign rd_idx = (op_reg == mcps_pkg::OP_ACK) ? path_reg[PIDX_W-1:0] : idx_reg;
    assign u_cur  = u_reg[idx_reg];
    assign w_cur  = win_reg[rd_idx];

    // loss: halve, then clamp up to the floor
    assign half_w  = w_cur >> 1;
    assign floor_w = {16'd0, minw_reg, 8'd0};

    always_comb
    begin
        if (loss_reg)
            quick_val = (half_w < floor_w) ? floor_w : half_w;
        else
            quick_val = (sq_reg == '0) ? '0 : mcps_pkg::WIN_MAX;
    end

    // quotient never exceeds 2^40 here only if w is large; saturate either way
    assign grow_sum = {1'b0, w_cur} + (WIN_W + 1)'(quo);
    assign grow_val = (grow_sum[WIN_W] || (quo[mcps_pkg::DIVIDEND_W-1:WIN_W] != '0))
                      ? mcps_pkg::WIN_MAX : grow_sum[WIN_W-1:0];

    assign win_wr = cmd.win_wr_quick | cmd.win_wr_grow;
    assign wr_val = cmd.win_wr_grow ? grow_val : quick_val;

    mcps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({sq_reg, 16'd0}),
        .divisor  (w_cur),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PATHS; i++)
                win_reg[i] <= mcps_pkg::WIN_RESET;
            minw_reg  <= mcps_pkg::MINW_RESET;
            op_reg    <= mcps_pkg::OP_SELECT;
            idx_reg   <= '0;
            best_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                minw_reg <= cfg_wr_data;
            if (win_wr)
                win_reg[path_reg[PIDX_W-1:0]] <= wr_val;
            if (cmd.load)
            begin
                op_reg    <= op;
                idx_reg   <= '0;
                best_reg  <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.idx_inc)
                    idx_reg <= idx_reg + 1'b1;
                if (cmd.take)
                begin
                    best_reg  <= idx_reg;
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < NUM_PATHS; i++)
                u_reg[i] <= unacked[i];
            path_reg <= ack_path;
            loss_reg <= loss;
            sq_reg   <= mcps_pkg::SQ_W'(ack_size) * mcps_pkg::SQ_W'(ack_size);
            nw_reg   <= '0;
        end
        else if (win_wr)
            nw_reg <= wr_val;
        if (cmd.take)
        begin
            u_best_reg <= u_cur;
            w_best_reg <= w_cur;
        end
        // cross products split into 32x32 and 32x8 pieces
        if (cmd.mul_en)
        begin
            pl_lo_reg <= (2*U_W)'(u_cur) * (2*U_W)'(w_best_reg[31:0]);
            pl_hi_reg <= WIN_W'(u_cur) * WIN_W'(w_best_reg[WIN_W-1:32]);
            pr_lo_reg <= (2*U_W)'(u_best_reg) * (2*U_W)'(w_cur[31:0]);
            pr_hi_reg <= WIN_W'(u_best_reg) * WIN_W'(w_cur[WIN_W-1:32]);
        end
        if (cmd.sum_en)
        begin
            lhs_reg <= PROD_W'(pl_lo_reg) + {pl_hi_reg, 32'd0};
            rhs_reg <= PROD_W'(pr_lo_reg) + {pr_hi_reg, 32'd0};
        end
        if (cmd.out_load)
        begin
            out_found_reg <= found_reg;
            out_path_reg  <= mcps_pkg::PATH_W'(best_reg);
            out_win_reg   <= nw_reg;
        end
    end

    always_comb
    begin
        sts.op_ack     = (op == mcps_pkg::OP_ACK);
        sts.elig       = {u_cur, 8'd0} < w_cur;
        sts.found      = found_reg;
        sts.last       = (idx_reg == IDX_LAST);
        sts.ratio_less = lhs_reg < rhs_reg;
        sts.path_ok    = {1'b0, path_reg} < NP;
        sts.loss       = loss_reg;
        sts.win_zero   = (w_cur == '0);
        sts.div_done   = div_done;
    end

    assign path_found  = out_found_reg;
    assign chosen_path = out_path_reg;
    assign new_window  = out_win_reg;

endmodule

/* rtl/mcps_ctrl.sv */
module mcps_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_stall,
    input  mcps_pkg::mcps_sts_t sts,
    output logic                in_stall,
    output logic                out_valid,
    output mcps_pkg::mcps_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_ACK  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sts.op_ack ? S_ACK : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.elig && sts.found)
                    state_next = S_MUL;
                else
                begin
                    cmd.take    = sts.elig;
                    cmd.idx_inc = !sts.last;
                    state_next  = sts.last ? S_DONE : S_SCAN;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.take    = sts.ratio_less;
                cmd.idx_inc = !sts.last;
                state_next  = sts.last ? S_DONE : S_SCAN;
            end
            S_ACK:
            begin
                // out-of-range path leaves state alone and reports zeros
                if (!sts.path_ok)
                    state_next = S_DONE;
                else if (sts.loss || sts.win_zero)
                begin
                    cmd.win_wr_quick = 1'b1;
                    state_next       = S_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.win_wr_grow = 1'b1;
                    state_next      = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

/* rtl/multipath_cwnd_path_scheduler.sv */
// Multipath congestion-window path scheduler.
// Input channel (in_valid / in_stall): op 0 selects a path from the four
// unacked_N counts; op 1 applies an acknowledgement (ack_path, ack_size, loss)
// to that path's Q32.8 window. Every item produces exactly one result on the
// output channel (out_valid / out_stall): path_found, chosen_path, new_window.
// The user must write min_window through cfg_wr_en / cfg_wr_data while idle;
// the block does not enforce it. One item is in work at a time; in_stall is
// high from the transfer until the result moves into the output register.
// Select: the result is set by the scan over paths, with a scan step for every
// path and a split cross multiply, sum and compare for each path that needs a
// ratio compare.
// Ack: on loss, a zero window or an out-of-range path the result is set
// directly; growth waits for the restoring divider, which yields one bit per
// cycle over the 48 dividend bits.
// A finished result sits in the output register while out_stall is high;
// the next item can be taken in the cycle after the result has moved there.
// Reset sets every window to 500 bytes and min_window to 500, and empties
// the output register.
module multipath_cwnd_path_scheduler #(
    parameter int NUM_PATHS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [mcps_pkg::MINW_W-1:0]       cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              op,
    input  logic [mcps_pkg::PATH_W-1:0]       ack_path,
    input  logic [mcps_pkg::SIZE_W-1:0]       ack_size,
    input  logic                              loss,
    input  logic [mcps_pkg::UNACK_W-1:0]      unacked_0,
    input  logic [mcps_pkg::UNACK_W-1:0]      unacked_1,
    input  logic [mcps_pkg::UNACK_W-1:0]      unacked_2,
    input  logic [mcps_pkg::UNACK_W-1:0]      unacked_3,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              path_found,
    output logic [mcps_pkg::PATH_W-1:0]       chosen_path,
    output logic [mcps_pkg::WIN_W-1:0]        new_window
);

`include "assert_macros.svh"

    mcps_pkg::mcps_cmd_t    cmd;
    mcps_pkg::mcps_sts_t    sts;
    mcps_pkg::unacked_vec_t unacked;

    assign unacked = {unacked_3, unacked_2, unacked_1, unacked_0};

    mcps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    mcps_dp #(
        .NUM_PATHS (NUM_PATHS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .op          (op),
        .ack_path    (ack_path),
        .ack_size    (ack_size),
        .loss        (loss),
        .unacked     (unacked),
        .path_found  (path_found),
        .chosen_path (chosen_path),
        .new_window  (new_window)
    );

    // a select result never carries a window
    `ASSERT_IMPL(a_res_excl, clk, rst_n, out_valid && path_found, new_window == '0)
    // chosen path lies within the configured paths
    `ASSERT_IMPL(a_path_range, clk, rst_n, out_valid && path_found, chosen_path < NUM_PATHS)
    // a waiting result is never overwritten
    `ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.out_load, !(out_valid && out_stall))
    // after a transfer in, the block is busy
    `ASSERT_NEXT(a_busy_after_load, clk, rst_n, cmd.load, in_stall)

endmodule
